### hw/rtl/bmv_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// bmv_pkg
// Shared types and constants of the band matrix-vector multiply block.
// ---------------------------------------------------------------------------
package bmv_pkg;

    localparam int MAX_DIM    = 64;
    localparam int BAND_ROWS  = 16;
    localparam int FRAC_BITS  = 16;
    localparam int DIM_W      = $clog2(MAX_DIM);
    localparam int BROW_W     = $clog2(BAND_ROWS);
    localparam int BAND_DEPTH = MAX_DIM * BAND_ROWS;
    localparam int BAND_AW    = $clog2(BAND_DEPTH);
    localparam int QDEPTH     = 4;
    localparam int QAW        = $clog2(QDEPTH);

    localparam logic [2:0] REG_TRANSPOSE = 3'd0;
    localparam logic [2:0] REG_ROWS      = 3'd1;
    localparam logic [2:0] REG_COLS      = 3'd2;
    localparam logic [2:0] REG_SUB       = 3'd3;
    localparam logic [2:0] REG_SUPER     = 3'd4;
    localparam logic [2:0] REG_ALPHA     = 3'd5;
    localparam logic [2:0] REG_BETA      = 3'd6;

    typedef enum logic [1:0] {
        CMD_BAND    = 2'd0,
        CMD_X       = 2'd1,
        CMD_Y       = 2'd2,
        CMD_COMPUTE = 2'd3
    } cmd_t;

    typedef struct packed {
        cmd_t               cmd;
        logic [BROW_W-1:0]  band_row;
        logic [DIM_W-1:0]   column;
        logic signed [31:0] value;
    } op_t;

    typedef struct packed {
        logic               transpose_mode;
        logic [6:0]         row_count;
        logic [6:0]         column_count;
        logic [2:0]         sub_diagonals;
        logic [2:0]         super_diagonals;
        logic signed [31:0] alpha_scale;
        logic signed [31:0] beta_scale;
    } cfg_t;

    typedef struct packed {
        logic push;
        logic full;
        logic [QAW:0] count;
    } q_status_t;

    function automatic logic signed [31:0] sat32(input logic signed [48:0] v);
        logic signed [31:0] r;
        if (v > 49'sd2147483647) r = 32'sh7fffffff;
        else if (v < -49'sd2147483648) r = 32'sh80000000;
        else r = v[31:0];
        return r;
    endfunction

endpackage
`default_nettype wire

### hw/rtl/band_matrix_vector_multiply.sv
`default_nettype none
// ---------------------------------------------------------------------------
// band_matrix_vector_multiply
// y = alpha*A*x + beta*y (or A transposed) over a band-stored matrix.
// ---------------------------------------------------------------------------
//  channel   dir  signals
//  s_axis    in   tvalid tready tuser(cmd) tdata(band_row,column,value)
//  m_axis    out  tvalid tready tlast tdata(y_index,y_value)
//  cfg       in   cfg_valid cfg_ready cfg_index cfg_data
//
//  load items are written while the back end is idle, so it stays ready for the next item.
//  a compute item reads each y element, then reads, multiplies and
//  accumulates each band product, and scales each element unless y
//  stays unchanged.
//  no clearing pass after reset; queue of 4 items between front and back.
//  output register lets the walk continue while a result waits.
module band_matrix_vector_multiply (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [1:0]  s_axis_tuser,   // cmd
    input  wire logic [47:0] s_axis_tdata,   // band_row, column, value, zero fill
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [39:0]      m_axis_tdata,   // y_index, y_value, zero fill
    output logic             m_axis_tlast,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [31:0] cfg_data
);
    import bmv_pkg::*;

    cfg_t      cfg_reg;
    op_t       f_op, q_op;
    logic      f_valid, f_ready, q_valid, q_ready;
    q_status_t q_stat;
    logic [5:0]         y_idx;
    logic signed [31:0] y_val;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.transpose_mode  <= 1'b0;
            cfg_reg.row_count       <= '0;
            cfg_reg.column_count    <= '0;
            cfg_reg.sub_diagonals   <= '0;
            cfg_reg.super_diagonals <= '0;
            cfg_reg.alpha_scale     <= 32'sd1 <<< FRAC_BITS;
            cfg_reg.beta_scale      <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_TRANSPOSE: cfg_reg.transpose_mode  <= cfg_data[0];
                REG_ROWS:      cfg_reg.row_count       <= cfg_data[6:0];
                REG_COLS:      cfg_reg.column_count    <= cfg_data[6:0];
                REG_SUB:       cfg_reg.sub_diagonals   <= cfg_data[2:0];
                REG_SUPER:     cfg_reg.super_diagonals <= cfg_data[2:0];
                REG_ALPHA:     cfg_reg.alpha_scale     <= cfg_data;
                REG_BETA:      cfg_reg.beta_scale      <= cfg_data;
                default: ;
            endcase
        end
    end

    bmv_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .in_cmd   (s_axis_tuser),
        .in_data  (s_axis_tdata),
        .op_valid (f_valid),
        .op_ready (f_ready),
        .op       (f_op)
    );

    bmv_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (f_valid),
        .push_ready (f_ready),
        .push_op    (f_op),
        .pop_valid  (q_valid),
        .pop_ready  (q_ready),
        .pop_op     (q_op),
        .status     (q_stat)
    );

    bmv_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .op_valid  (q_valid),
        .op_ready  (q_ready),
        .op        (q_op),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_index (y_idx),
        .out_value (y_val),
        .out_last  (m_axis_tlast)
    );

    assign m_axis_tdata = {2'b00, y_val, y_idx};

`ifndef SYNTHESIS
    a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        q_stat.count <= QDEPTH[QAW:0])
        else $error("queue count beyond depth");
    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        q_stat.push |-> !q_stat.full)
        else $error("push into full queue");
`endif
endmodule
`default_nettype wire

### hw/rtl/bmv_front.sv
`default_nettype none
// ---------------------------------------------------------------------------
// bmv_front
// Accepts input items, decodes the command and hands them to the queue.
// ---------------------------------------------------------------------------
module bmv_front (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [1:0]  in_cmd,
    input  wire logic [47:0] in_data,
    output logic             op_valid,
    input  wire logic        op_ready,
    output bmv_pkg::op_t     op
);
    import bmv_pkg::*;

    logic hold_reg;
    op_t  op_reg;

    assign in_ready = !hold_reg || op_ready;
    assign op_valid = hold_reg;
    assign op       = op_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            hold_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            op_reg.cmd      <= cmd_t'(in_cmd);
            op_reg.band_row <= in_data[BROW_W-1:0];
            op_reg.column   <= in_data[BROW_W +: DIM_W];
            op_reg.value    <= in_data[BROW_W+DIM_W +: 32];
        end
    end
endmodule
`default_nettype wire

### hw/rtl/bmv_queue.sv
`default_nettype none
// ---------------------------------------------------------------------------
// bmv_queue
// Short queue of decoded items between the front and the back.
// ---------------------------------------------------------------------------
module bmv_queue (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push_valid,
    output logic               push_ready,
    input  bmv_pkg::op_t       push_op,
    output logic               pop_valid,
    input  wire logic          pop_ready,
    output bmv_pkg::op_t       pop_op,
    output bmv_pkg::q_status_t status
);
    import bmv_pkg::*;

    op_t            mem [QDEPTH];
    logic [QAW-1:0] wr_reg, rd_reg;
    logic [QAW:0]   cnt_reg;
    logic           push, pop;

    assign push_ready = (cnt_reg != QDEPTH[QAW:0]);
    assign pop_valid  = (cnt_reg != '0);
    assign pop_op     = mem[rd_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;
    assign status.push  = push;
    assign status.full  = !push_ready;
    assign status.count = cnt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push) wr_reg <= wr_reg + 1'b1;
            if (pop)  rd_reg <= rd_reg + 1'b1;
            if (push && !pop) cnt_reg <= cnt_reg + 1'b1;
            else if (pop && !push) cnt_reg <= cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push) mem[wr_reg] <= push_op;
    end
endmodule
`default_nettype wire

### hw/rtl/bmv_back.sv
`default_nettype none
// ---------------------------------------------------------------------------
// bmv_back
// Holds the band, x and y stores, performs loads and walks the band for a
// compute item, emitting every y element.
// ---------------------------------------------------------------------------
module bmv_back (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  bmv_pkg::cfg_t     cfg,
    input  wire logic         op_valid,
    output logic              op_ready,
    input  bmv_pkg::op_t      op,
    output logic              out_valid,
    input  wire logic         out_ready,
    output logic [5:0]        out_index,
    output logic signed [31:0] out_value,
    output logic              out_last
);
    import bmv_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_YRD, S_PRD, S_PMUL, S_PACC, S_DOT, S_MULT, S_MULS, S_FIN, S_EMIT
    } state_t;

    logic signed [31:0] band_mem [BAND_DEPTH];
    logic signed [31:0] x_mem [MAX_DIM];
    logic signed [31:0] y_mem [MAX_DIM];

    state_t             state_reg;
    logic [DIM_W:0]     o_reg, leny_reg, lenx_reg;
    logic [DIM_W-1:0]   p_reg, p_hi_reg;
    logic               unch_reg;
    logic signed [63:0] acc_reg, prod_reg;
    logic signed [31:0] dot_reg, res_reg;
    logic signed [31:0] band_rd_reg, x_rd_reg, y_rd_reg;
    logic               ovalid_reg, olast_reg;
    logic [5:0]         oidx_reg;
    logic signed [31:0] oval_reg;

    logic [DIM_W:0]     m_dim, n_dim, leny, lenx;
    logic               unchanged;
    logic signed [DIM_W+2:0] lo_s, hi_s, lenx_m1;
    logic [2:0]         lowoff, highoff;
    logic [DIM_W-1:0]   i_idx, j_idx;
    logic [BROW_W-1:0]  r_idx;
    logic [BAND_AW-1:0] band_addr;
    logic signed [64:0] acc_sum, acc_rnd;
    logic signed [63:0] acc_next;
    logic signed [47:0] acc_sh;
    logic signed [64:0] t_rnd, s_rnd;
    logic signed [48:0] ts_sum;
    logic               out_free;
    logic               emit_now;
    logic signed [31:0] emit_val;

    assign m_dim = (cfg.row_count > 7'(MAX_DIM)) ? (DIM_W+1)'(MAX_DIM) : cfg.row_count[DIM_W:0];
    assign n_dim = (cfg.column_count > 7'(MAX_DIM)) ? (DIM_W+1)'(MAX_DIM)
                                                    : cfg.column_count[DIM_W:0];
    assign leny = cfg.transpose_mode ? n_dim : m_dim;
    assign lenx = cfg.transpose_mode ? m_dim : n_dim;
    assign unchanged = (m_dim == '0) || (n_dim == '0) ||
        (cfg.alpha_scale == 32'sd0 && cfg.beta_scale == 32'sd1 <<< FRAC_BITS);

    // band walk range of p for the current y element
    assign lowoff  = cfg.transpose_mode ? cfg.super_diagonals : cfg.sub_diagonals;
    assign highoff = cfg.transpose_mode ? cfg.sub_diagonals : cfg.super_diagonals;
    assign lo_s    = $signed({2'b00, o_reg}) - $signed({{DIM_W{1'b0}}, lowoff});
    assign hi_s    = $signed({2'b00, o_reg}) + $signed({{DIM_W{1'b0}}, highoff});
    assign lenx_m1 = $signed({2'b00, lenx_reg}) - (DIM_W+3)'(1);

    assign i_idx     = cfg.transpose_mode ? p_reg : o_reg[DIM_W-1:0];
    assign j_idx     = cfg.transpose_mode ? o_reg[DIM_W-1:0] : p_reg;
    assign r_idx     = BROW_W'({1'b0, cfg.super_diagonals} + i_idx - j_idx);
    assign band_addr = {j_idx, r_idx};

    // saturating accumulate and round of the dot product
    assign acc_sum  = {acc_reg[63], acc_reg} + {prod_reg[63], prod_reg};
    assign acc_next = (acc_sum[64] != acc_sum[63])
                    ? (acc_sum[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}}) : acc_sum[63:0];
    assign acc_rnd  = {acc_reg[63], acc_reg} + (65'sd1 <<< (FRAC_BITS-1));
    assign acc_sh   = (acc_rnd[64] != acc_rnd[63]) ? 48'sh7fffffffffff
                    : 48'(acc_rnd[63:0] >>> FRAC_BITS);

    assign t_rnd  = ({prod_reg[63], prod_reg} + (65'sd1 <<< (FRAC_BITS-1))) >>> FRAC_BITS;
    assign s_rnd  = ({acc_reg[63], acc_reg} + (65'sd1 <<< (FRAC_BITS-1))) >>> FRAC_BITS;
    assign ts_sum = 49'(t_rnd) + 49'(s_rnd);

    assign out_free = !ovalid_reg || out_ready;
    assign emit_now = (state_reg == S_EMIT) && out_free;
    assign emit_val = unch_reg ? y_rd_reg : res_reg;

    assign op_ready  = (state_reg == S_IDLE);
    assign out_valid = ovalid_reg;
    assign out_index = oidx_reg;
    assign out_value = oval_reg;
    assign out_last  = olast_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            ovalid_reg <= 1'b0;
            o_reg      <= '0;
            leny_reg   <= '0;
            lenx_reg   <= '0;
            unch_reg   <= 1'b0;
            p_reg      <= '0;
            p_hi_reg   <= '0;
            acc_reg    <= '0;
            prod_reg   <= '0;
            dot_reg    <= '0;
            res_reg    <= '0;
            oidx_reg   <= '0;
            oval_reg   <= '0;
            olast_reg  <= 1'b0;
        end
        else
        begin
            if (out_ready && !emit_now) ovalid_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (op_valid && op.cmd == CMD_COMPUTE && leny != '0)
                    begin
                        o_reg     <= '0;
                        leny_reg  <= leny;
                        lenx_reg  <= lenx;
                        unch_reg  <= unchanged;
                        state_reg <= S_YRD;
                    end
                end
                S_YRD:
                begin
                    acc_reg  <= '0;
                    p_reg    <= (lo_s < 0) ? '0 : lo_s[DIM_W-1:0];
                    p_hi_reg <= (hi_s > lenx_m1) ? lenx_m1[DIM_W-1:0] : hi_s[DIM_W-1:0];
                    if (unch_reg) state_reg <= S_EMIT;
                    else if ((lo_s < 0 ? 0 : lo_s) > ((hi_s > lenx_m1) ? lenx_m1 : hi_s))
                        state_reg <= S_DOT;
                    else state_reg <= S_PRD;
                end
                S_PRD:  state_reg <= S_PMUL;
                S_PMUL:
                begin
                    prod_reg  <= band_rd_reg * x_rd_reg;
                    state_reg <= S_PACC;
                end
                S_PACC:
                begin
                    acc_reg <= acc_next;
                    p_reg   <= p_reg + 1'b1;
                    state_reg <= (p_reg == p_hi_reg) ? S_DOT : S_PRD;
                end
                S_DOT:
                begin
                    dot_reg   <= sat32(49'(acc_sh));
                    state_reg <= S_MULT;
                end
                S_MULT:
                begin
                    prod_reg  <= cfg.alpha_scale * dot_reg;
                    state_reg <= S_MULS;
                end
                S_MULS:
                begin
                    acc_reg   <= cfg.beta_scale * y_rd_reg;
                    state_reg <= S_FIN;
                end
                S_FIN:
                begin
                    res_reg   <= sat32(ts_sum);
                    state_reg <= S_EMIT;
                end
                S_EMIT:
                begin
                    if (out_free)
                    begin
                        ovalid_reg <= 1'b1;
                        oidx_reg   <= o_reg[5:0];
                        oval_reg   <= emit_val;
                        olast_reg  <= (o_reg == leny_reg - 1'b1);
                        o_reg      <= o_reg + 1'b1;
                        state_reg  <= (o_reg == leny_reg - 1'b1) ? S_IDLE : S_YRD;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // stores: loads write in idle, the walk reads with registered data
    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && op_valid && op.cmd == CMD_BAND)
            band_mem[{op.column, op.band_row}] <= op.value;
        band_rd_reg <= band_mem[band_addr];
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && op_valid && op.cmd == CMD_X)
            x_mem[op.column] <= op.value;
        x_rd_reg <= x_mem[p_reg];
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && op_valid && op.cmd == CMD_Y)
            y_mem[op.column] <= op.value;
        else if (emit_now)
            y_mem[o_reg[DIM_W-1:0]] <= emit_val;
        if (state_reg == S_YRD)
            y_rd_reg <= y_mem[o_reg[DIM_W-1:0]];
    end
endmodule
`default_nettype wire

### tb/sv/tb_band_matrix_vector_multiply.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_band_matrix_vector_multiply
// Loads band matrix, x and y elements over the input stream, runs compute
// items under a series of register settings and checks every emitted y
// element against a fixed-point predictor kept in the testbench.
// ---------------------------------------------------------------------------
module tb_band_matrix_vector_multiply;
    import bmv_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int HOLD_CYCLES    = 500;
    localparam int ONE_Q          = 65536;

    typedef struct {
        cmd_t               cmd;
        logic [3:0]         brow;
        logic [5:0]         col;
        logic signed [31:0] val;
    } load_item_t;

    typedef struct {
        logic [5:0]         idx;
        logic signed [31:0] val;
        logic               last;
    } y_elem_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [1:0]  s_axis_tuser = '0;
    logic [47:0] s_axis_tdata = '0;     // band_row, column, value, zero fill
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [39:0] m_axis_tdata;          // y_index, y_value, zero fill
    logic        m_axis_tlast;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = '0;
    logic [31:0] cfg_data = '0;

    band_matrix_vector_multiply u_top (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tuser(s_axis_tuser), .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always #10 clk = ~clk;

    // predictor state
    logic               mdl_transpose;
    int                 mdl_rows, mdl_cols, mdl_sub, mdl_super;
    logic signed [31:0] mdl_alpha, mdl_beta;
    logic signed [31:0] band_mem [BAND_DEPTH];
    logic signed [31:0] x_mem [MAX_DIM];
    logic signed [31:0] y_mem [MAX_DIM];

    // entries already covered by queued writes, tracked while generating
    bit band_written [BAND_DEPTH];
    bit x_written [MAX_DIM];
    bit y_written [MAX_DIM];

    load_item_t pending_items [$];
    y_elem_t    y_expected [$];
    int         fail_count = 0;
    bit         calm = 1'b0;
    bit         hold_req = 1'b0;

    task automatic report_mismatch(input string msg);
        $display("MISMATCH @%0t: %s", $realtime, msg);
        fail_count++;
    endtask

    function automatic longint sat_add(input longint a, input longint b);
        longint s;
        s = a + b;
        if (a >= 0 && b >= 0 && s < 0) return 64'sh7fffffffffffffff;
        if (a < 0 && b < 0 && s >= 0) return 64'sh8000000000000000;
        return s;
    endfunction

    function automatic longint round_q(input longint v);
        longint w;
        w = sat_add(v, longint'(1) <<< (FRAC_BITS - 1));
        return w >>> FRAC_BITS;
    endfunction

    function automatic logic signed [31:0] clip32(input longint v);
        if (v > 64'sd2147483647) return 32'sh7fffffff;
        if (v < -64'sd2147483648) return 32'sh80000000;
        return v[31:0];
    endfunction

    // y = alpha*op(A)*x + beta*y over the band, queued in index order
    task automatic predict_y_update();
        int m, n, leny, lenx, i, j, r;
        bit keep;
        longint acc, t, s;
        logic signed [31:0] dotp, res;
        y_elem_t e;
        m = (mdl_rows > MAX_DIM) ? MAX_DIM : mdl_rows;
        n = (mdl_cols > MAX_DIM) ? MAX_DIM : mdl_cols;
        leny = mdl_transpose ? n : m;
        lenx = mdl_transpose ? m : n;
        keep = (m == 0 || n == 0 || (mdl_alpha == 0 && mdl_beta == ONE_Q));
        for (int o = 0; o < leny; o++) begin
            res = y_mem[o];
            if (!keep) begin
                acc = 0;
                for (int p = 0; p < lenx; p++) begin
                    i = mdl_transpose ? p : o;
                    j = mdl_transpose ? o : p;
                    r = mdl_super + i - j;
                    if (i - j > mdl_sub || j - i > mdl_super) continue;
                    if (r < 0 || r >= BAND_ROWS) continue;
                    acc = sat_add(acc, longint'(band_mem[j*BAND_ROWS + r]) * longint'(x_mem[p]));
                end
                dotp = clip32(round_q(acc));
                t = round_q(longint'(mdl_alpha) * longint'(dotp));
                s = round_q(longint'(mdl_beta) * longint'(y_mem[o]));
                res = clip32(sat_add(s, t));
                y_mem[o] = res;
            end
            e.idx = o[5:0];
            e.val = res;
            e.last = (o == leny - 1);
            y_expected.push_back(e);
        end
    endtask

    task automatic apply_item(input load_item_t it);
        case (it.cmd)
            CMD_BAND:    band_mem[it.col*BAND_ROWS + it.brow] = it.val;
            CMD_X:       x_mem[it.col] = it.val;
            CMD_Y:       y_mem[it.col] = it.val;
            CMD_COMPUTE: predict_y_update();
            default: ;
        endcase
    endtask

    // input driver
    int gap_left = 0;
    always @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            apply_item(pending_items.pop_front());
        end
        if (gap_left > 0)
        begin
            gap_left <= gap_left - 1;
            s_axis_tvalid <= 1'b0;
        end
        else if (rst_n && pending_items.size() > 0 && !calm
                 && !(s_axis_tvalid && !s_axis_tready) && $urandom_range(0, 9) == 0)
        begin
            gap_left <= $urandom_range(1, 18) - 1;
            s_axis_tvalid <= 1'b0;
        end
        else if (rst_n && pending_items.size() > 0)
        begin
            s_axis_tvalid <= 1'b1;
            s_axis_tuser <= pending_items[0].cmd;
            s_axis_tdata <= {6'd0, pending_items[0].val, pending_items[0].col,
                             pending_items[0].brow};
        end
        else
        begin
            s_axis_tvalid <= 1'b0;
        end
    end

    // result monitor
    int stall_left = 0;
    int hold_left = 0;
    bit hold_done = 1'b0;
    always @(posedge clk)
    begin
        y_elem_t e;
        if (m_axis_tvalid && m_axis_tready)
        begin
            if (y_expected.size() == 0)
            begin
                report_mismatch($sformatf("unexpected y item idx %0d", m_axis_tdata[5:0]));
            end
            else
            begin
                e = y_expected.pop_front();
                if (m_axis_tdata[5:0] !== e.idx)
                    report_mismatch($sformatf("y_index %0d, want %0d", m_axis_tdata[5:0], e.idx));
                if ($signed(m_axis_tdata[37:6]) !== e.val)
                    report_mismatch($sformatf("y_value[%0d] %0d, want %0d", e.idx,
                                              $signed(m_axis_tdata[37:6]), e.val));
                if (m_axis_tlast !== e.last)
                    report_mismatch($sformatf("last[%0d] %b, want %b", e.idx,
                                              m_axis_tlast, e.last));
                if (m_axis_tdata[39:38] !== 2'b00)
                    report_mismatch("nonzero fill bits in result");
            end
        end
        if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end
        else if (hold_req && !hold_done && m_axis_tvalid)
        begin
            // long back-pressure so the input side stalls
            hold_done <= 1'b1;
            hold_left <= HOLD_CYCLES - 1;
            m_axis_tready <= 1'b0;
        end
        else if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            m_axis_tready <= 1'b0;
        end
        else if (!calm && $urandom_range(0, 9) == 0)
        begin
            stall_left <= $urandom_range(1, 18) - 1;
            m_axis_tready <= 1'b0;
        end
        else
        begin
            m_axis_tready <= rst_n;
        end
    end

    // watchdog on cycles without any accepted item
    int quiet_cycles = 0;
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || (cfg_valid && cfg_ready) || !rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles == WATCHDOG_LIMIT)
        begin
            $display("timeout: no item accepted for %0d cycles", WATCHDOG_LIMIT);
            $display("*** FAILED ***");
            $finish;
        end
    end

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            REG_TRANSPOSE: mdl_transpose = data[0];
            REG_ROWS:      mdl_rows = data[6:0];
            REG_COLS:      mdl_cols = data[6:0];
            REG_SUB:       mdl_sub = data[2:0];
            REG_SUPER:     mdl_super = data[2:0];
            REG_ALPHA:     mdl_alpha = data;
            REG_BETA:      mdl_beta = data;
            default: ;
        endcase
    endtask

    task automatic wait_idle();
        do @(posedge clk);
        while (pending_items.size() != 0 || y_expected.size() != 0 || s_axis_tvalid);
        repeat (40) @(posedge clk);
    endtask

    task automatic configure(input bit tm, input int m, input int n, input int kl,
                             input int ku, input logic [31:0] a, input logic [31:0] b);
        wait_idle();
        write_reg(REG_TRANSPOSE, tm);
        write_reg(REG_ROWS, m);
        write_reg(REG_COLS, n);
        write_reg(REG_SUB, kl);
        write_reg(REG_SUPER, ku);
        write_reg(REG_ALPHA, a);
        write_reg(REG_BETA, b);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [31:0] rand_value();
        if ($urandom_range(0, 3) == 0) return $urandom;
        return $urandom_range(0, 1 << 19) - (1 << 18);
    endfunction

    function automatic logic [31:0] rand_scale();
        if ($urandom_range(0, 5) == 0) return $urandom;
        return $urandom_range(0, 1 << 18) - (1 << 17);
    endfunction

    task automatic queue_item(input cmd_t c, input int br, input int col, input logic [31:0] v);
        load_item_t it;
        it.cmd = c;
        it.brow = br[3:0];
        it.col = col[5:0];
        it.val = v;
        if (c == CMD_BAND) band_written[col*BAND_ROWS + br] = 1'b1;
        if (c == CMD_X) x_written[col] = 1'b1;
        if (c == CMD_Y) y_written[col] = 1'b1;
        pending_items.push_back(it);
    endtask

    // random loads, then any element the compute will read but nobody wrote
    task automatic queue_run(input int nloads);
        int leny, lenx, r;
        for (int k = 0; k < nloads; k++)
            queue_item(cmd_t'($urandom_range(0, 2)), $urandom_range(0, 15),
                       $urandom_range(0, 63), rand_value());
        leny = mdl_transpose ? mdl_cols : mdl_rows;
        lenx = mdl_transpose ? mdl_rows : mdl_cols;
        for (int o = 0; o < leny; o++)
            if (!y_written[o]) queue_item(CMD_Y, 0, o, rand_value());
        if (mdl_rows != 0 && mdl_cols != 0)
        begin
            for (int p = 0; p < lenx; p++)
                if (!x_written[p]) queue_item(CMD_X, 0, p, rand_value());
            for (int j = 0; j < mdl_cols; j++)
                for (int i = 0; i < mdl_rows; i++)
                begin
                    r = mdl_super + i - j;
                    if (i - j <= mdl_sub && j - i <= mdl_super && !band_written[j*BAND_ROWS + r])
                        queue_item(CMD_BAND, r, j, rand_value());
                end
        end
        queue_item(CMD_COMPUTE, $urandom_range(0, 15), $urandom_range(0, 63), $urandom);
    endtask

    task automatic phase(input bit tm, input int m, input int n, input int kl, input int ku,
                         input logic [31:0] a, input logic [31:0] b, input int runs,
                         input int nloads);
        configure(tm, m, n, kl, ku, a, b);
        for (int k = 0; k < runs; k++) queue_run(nloads);
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        // registers after reset
        mdl_transpose = 0; mdl_rows = 0; mdl_cols = 0; mdl_sub = 0; mdl_super = 0;
        mdl_alpha = ONE_Q; mdl_beta = 0;
        write_reg(3'd7, 32'hffffffff);  // index past the list, no effect
        cfg_valid <= 1'b0;
        configure(0, 4, 3, 1, 2, ONE_Q, ONE_Q / 2);
        // extremes of every field and every command
        queue_item(CMD_BAND, 15, 63, 32'h7fffffff);
        queue_item(CMD_BAND, 0, 0, 32'h7fffffff);
        queue_item(CMD_BAND, 1, 0, 32'h80000000);
        queue_item(CMD_BAND, 2, 0, 32'h80000000);
        queue_item(CMD_X, 0, 0, 32'h7fffffff);
        queue_item(CMD_X, 0, 63, 32'h80000000);
        queue_item(CMD_X, 0, 1, 32'h80000000);
        queue_item(CMD_Y, 0, 63, 32'hffffffff);
        queue_item(CMD_Y, 0, 0, 32'h7fffffff);
        queue_item(CMD_Y, 0, 1, 32'h80000000);
        queue_item(CMD_Y, 0, 2, 32'h00000000);
        queue_run(0);
        queue_run(2);

        hold_req = 1'b1;
        phase(0, 8, 8, 2, 2, rand_scale(), rand_scale(), 3, 6);
        phase(1, 6, 10, 2, 3, rand_scale(), rand_scale(), 2, 6);
        phase(0, 0, 12, 1, 1, rand_scale(), rand_scale(), 2, 5);    // nothing emitted
        phase(1, 0, 12, 1, 1, rand_scale(), rand_scale(), 2, 5);    // y unchanged
        phase(0, 9, 0, 2, 2, rand_scale(), rand_scale(), 2, 5);
        phase(0, 8, 8, 2, 1, 0, ONE_Q, 2, 5);                       // alpha 0, beta 1
        phase(1, 8, 8, 1, 2, 32'hffff0000, 0, 2, 5);                // beta 0
        phase(0, 6, 6, 7, 7, 0, rand_scale(), 2, 5);                // scale only
        phase(0, 8, 8, 1, 1, 32'h7fffffff, 32'h80000000, 2, 5);
        phase(1, 8, 8, 2, 0, 32'h80000000, 32'h7fffffff, 2, 5);
        phase(0, 64, 2, 1, 1, rand_scale(), rand_scale(), 1, 0);
        phase(1, 2, 64, 0, 1, rand_scale(), rand_scale(), 1, 0);
        phase(1, 1, 1, 0, 0, rand_scale(), rand_scale(), 2, 5);
        for (int k = 0; k < 2; k++)
            phase($urandom_range(0, 1), $urandom_range(1, 12), $urandom_range(1, 12),
                  $urandom_range(0, 7), $urandom_range(0, 7), rand_scale(), rand_scale(),
                  2, 6);
        wait_idle();
        calm = 1'b1;
        phase($urandom_range(0, 1), 12, 10, 3, 4, rand_scale(), rand_scale(), 2, 6);
        wait_idle();
        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

### band_matrix_vector_multiply.f
hw/rtl/bmv_pkg.sv
hw/rtl/bmv_front.sv
hw/rtl/bmv_queue.sv
hw/rtl/bmv_back.sv
hw/rtl/band_matrix_vector_multiply.sv
tb/sv/tb_band_matrix_vector_multiply.sv
